>>> rtl/lca_pkg.sv
// Shared widths, codes and constants of the lowest common ancestor engine.
package lca_pkg;

    localparam int ID_W = 10;

    typedef logic [ID_W-1:0] t_id;

    localparam t_id DEPTH_MAX = '1;

    typedef enum logic {
        OP_ATTACH = 1'b0,
        OP_QUERY  = 1'b1
    } t_op;

endpackage

>>> rtl/lca_if.sv
// Request and response channel interfaces of the lowest common ancestor engine.
interface lca_req_if;
    logic             valid;
    logic             ready;
    logic             operation;
    lca_pkg::t_id     node_id;
    lca_pkg::t_id     other_node;

    modport source (output valid, output operation, output node_id, output other_node,
                    input ready);
    modport sink (input valid, input operation, input node_id, input other_node,
                  output ready);
endinterface

interface lca_rsp_if;
    logic             valid;
    logic             ready;
    lca_pkg::t_id     ancestor;
    lca_pkg::t_id     level;

    modport source (output valid, output ancestor, output level, input ready);
    modport sink (input valid, input ancestor, input level, output ready);
endinterface

>>> rtl/lca_tables.sv
// Jump and depth memories with one write port and two registered read ports each.
module lca_tables #(
    parameter int SLOT_W = 10,
    parameter int LVL_W  = 4
) (
    input  logic                      i_clk,
    input  logic                      i_jmp_we,
    input  logic [SLOT_W+LVL_W-1:0]   i_jmp_waddr,
    input  lca_pkg::t_id              i_jmp_wdata,
    input  logic [SLOT_W+LVL_W-1:0]   i_jmp_raddr_a,
    input  logic [SLOT_W+LVL_W-1:0]   i_jmp_raddr_b,
    output lca_pkg::t_id              o_jmp_rdata_a,
    output lca_pkg::t_id              o_jmp_rdata_b,
    input  logic                      i_dep_we,
    input  logic [SLOT_W-1:0]         i_dep_waddr,
    input  lca_pkg::t_id              i_dep_wdata,
    input  logic [SLOT_W-1:0]         i_dep_raddr_a,
    input  logic [SLOT_W-1:0]         i_dep_raddr_b,
    output lca_pkg::t_id              o_dep_rdata_a,
    output lca_pkg::t_id              o_dep_rdata_b
);

    localparam int JA_W = SLOT_W + LVL_W;

    lca_pkg::t_id r_jmp_mem [2**JA_W];
    lca_pkg::t_id r_dep_mem [2**SLOT_W];
    lca_pkg::t_id r_jmp_a;
    lca_pkg::t_id r_jmp_b;
    lca_pkg::t_id r_dep_a;
    lca_pkg::t_id r_dep_b;

    always_ff @(posedge i_clk) begin
        if (i_jmp_we) begin
            r_jmp_mem[i_jmp_waddr] <= i_jmp_wdata;
        end
        r_jmp_a <= r_jmp_mem[i_jmp_raddr_a];
        r_jmp_b <= r_jmp_mem[i_jmp_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_dep_we) begin
            r_dep_mem[i_dep_waddr] <= i_dep_wdata;
        end
        r_dep_a <= r_dep_mem[i_dep_raddr_a];
        r_dep_b <= r_dep_mem[i_dep_raddr_b];
    end

    assign o_jmp_rdata_a = r_jmp_a;
    assign o_jmp_rdata_b = r_jmp_b;
    assign o_dep_rdata_a = r_dep_a;
    assign o_dep_rdata_b = r_dep_b;

endmodule

>>> rtl/tree_lca_binary_lifting.sv
// Binary-lifting lowest common ancestor engine: sequencer over shared jump and depth tables.
// An attach writes the depth and jump level zero, then reads and writes each higher level; a root attach
// points every level at itself. A query compares depths, lifts the deeper node by the set bits of the
// distance and then descends from the top level; each step that follows a jump waits on one registered read.
// One request is in work at a time; a new one is taken only in idle and when the response register is empty or read.
// Synchronous active-low reset clears the sequencer, the response valid and the root to zero;
// table contents are undefined until written.
module tree_lca_binary_lifting #(
    parameter int MAX_NODES  = 1024,
    parameter int LOG_LEVELS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  lca_pkg::t_id  i_cfg_wr_data,
    lca_req_if.sink       i_req,
    lca_rsp_if.source     o_rsp
);

    localparam int SLOT_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LVL_W  = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int JA_W   = SLOT_W + LVL_W;
    localparam int LIFT_N = (LOG_LEVELS < lca_pkg::ID_W) ? LOG_LEVELS : lca_pkg::ID_W;
    localparam logic [LVL_W-1:0] LVL_LAST  = LVL_W'(LOG_LEVELS - 1);
    localparam logic [LVL_W-1:0] LIFT_LAST = LVL_W'(LIFT_N - 1);

    typedef enum logic [14:0] {
        ST_IDLE     = 15'h0001,
        ST_ROOT     = 15'h0002,
        ST_A_DEP    = 15'h0004,
        ST_A_RD     = 15'h0008,
        ST_A_WR     = 15'h0010,
        ST_Q_DEP    = 15'h0020,
        ST_Q_LIFT   = 15'h0040,
        ST_Q_LWAIT  = 15'h0080,
        ST_Q_CMP    = 15'h0100,
        ST_Q_DR     = 15'h0200,
        ST_Q_DW     = 15'h0400,
        ST_Q_FR     = 15'h0800,
        ST_Q_FW     = 15'h1000,
        ST_Q_RES    = 15'h2000,
        ST_SPARE    = 15'h4000
    } t_state;

    function automatic logic [SLOT_W-1:0] f_slot(input lca_pkg::t_id id);
        lca_pkg::t_id rem;
        rem = id;
        for (int k = lca_pkg::ID_W - 1; k >= 0; k--) begin
            if (32'(rem) >= (MAX_NODES << k)) begin
                rem = lca_pkg::ID_W'(32'(rem) - (MAX_NODES << k));
            end
        end
        return SLOT_W'(rem);
    endfunction

    t_state             r_state, n_state;
    lca_pkg::t_id       r_u, n_u;
    lca_pkg::t_id       r_v, n_v;
    lca_pkg::t_id       r_delta, n_delta;
    lca_pkg::t_id       r_res, n_res;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    lca_pkg::t_id       r_root;
    logic               r_out_valid, n_out_valid;
    lca_pkg::t_id       r_out_anc, n_out_anc;
    lca_pkg::t_id       r_out_lvl, n_out_lvl;

    logic               jmp_we;
    logic [JA_W-1:0]    jmp_waddr;
    lca_pkg::t_id       jmp_wdata;
    logic [JA_W-1:0]    jmp_raddr_a;
    logic [JA_W-1:0]    jmp_raddr_b;
    lca_pkg::t_id       jmp_rdata_a;
    lca_pkg::t_id       jmp_rdata_b;
    logic               dep_we;
    logic [SLOT_W-1:0]  dep_waddr;
    lca_pkg::t_id       dep_wdata;
    logic [SLOT_W-1:0]  dep_raddr_a;
    logic [SLOT_W-1:0]  dep_raddr_b;
    lca_pkg::t_id       dep_rdata_a;
    lca_pkg::t_id       dep_rdata_b;
    lca_pkg::t_id       next_depth;
    lca_pkg::t_id       lift_bits;
    logic               req_fire;

    assign i_req.ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign req_fire    = i_req.valid && i_req.ready;

    assign next_depth = (dep_rdata_b == lca_pkg::DEPTH_MAX) ? dep_rdata_b
                                                             : dep_rdata_b + 1'b1;
    assign lift_bits  = r_delta >> r_lvl;

    always_comb begin
        n_state     = r_state;
        n_u         = r_u;
        n_v         = r_v;
        n_delta     = r_delta;
        n_res       = r_res;
        n_lvl       = r_lvl;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_anc   = r_out_anc;
        n_out_lvl   = r_out_lvl;
        jmp_we      = 1'b0;
        jmp_waddr   = '0;
        jmp_wdata   = '0;
        jmp_raddr_a = '0;
        jmp_raddr_b = '0;
        dep_we      = 1'b0;
        dep_waddr   = '0;
        dep_wdata   = '0;
        dep_raddr_a = '0;
        dep_raddr_b = '0;
        case (r_state)
            ST_IDLE: begin
                dep_raddr_a = f_slot(i_req.node_id);
                dep_raddr_b = f_slot(i_req.other_node);
                if (req_fire) begin
                    n_u   = i_req.node_id;
                    n_v   = i_req.other_node;
                    n_lvl = '0;
                    if (i_req.operation == lca_pkg::OP_QUERY) begin
                        n_state = ST_Q_DEP;
                    end else if (i_req.node_id == r_root) begin
                        n_state = ST_ROOT;
                    end else begin
                        n_state = ST_A_DEP;
                    end
                end
            end
            ST_ROOT: begin
                jmp_we    = 1'b1;
                jmp_waddr = {f_slot(r_u), r_lvl};
                jmp_wdata = r_u;
                dep_we    = 1'b1;
                dep_waddr = f_slot(r_u);
                dep_wdata = '0;
                if (r_lvl == LVL_LAST) begin
                    n_out_valid = 1'b1;
                    n_out_anc   = r_u;
                    n_out_lvl   = '0;
                    n_state     = ST_IDLE;
                end else begin
                    n_lvl = r_lvl + 1'b1;
                end
            end
            ST_A_DEP: begin
                dep_we    = 1'b1;
                dep_waddr = f_slot(r_u);
                dep_wdata = next_depth;
                jmp_we    = 1'b1;
                jmp_waddr = {f_slot(r_u), LVL_W'(0)};
                jmp_wdata = r_v;
                n_delta   = next_depth;
                if (r_lvl == LVL_LAST) begin
                    n_out_valid = 1'b1;
                    n_out_anc   = r_u;
                    n_out_lvl   = next_depth;
                    n_state     = ST_IDLE;
                end else begin
                    n_lvl   = r_lvl + 1'b1;
                    n_state = ST_A_RD;
                end
            end
            ST_A_RD: begin
                jmp_raddr_a = {f_slot(r_v), LVL_W'(r_lvl - 1'b1)};
                n_state     = ST_A_WR;
            end
            ST_A_WR: begin
                jmp_we    = 1'b1;
                jmp_waddr = {f_slot(r_u), r_lvl};
                jmp_wdata = jmp_rdata_a;
                n_v       = jmp_rdata_a;
                if (r_lvl == LVL_LAST) begin
                    n_out_valid = 1'b1;
                    n_out_anc   = r_u;
                    n_out_lvl   = r_delta;
                    n_state     = ST_IDLE;
                end else begin
                    n_lvl   = r_lvl + 1'b1;
                    n_state = ST_A_RD;
                end
            end
            ST_Q_DEP: begin
                if (dep_rdata_a > dep_rdata_b) begin
                    n_u     = r_v;
                    n_v     = r_u;
                    n_delta = dep_rdata_a - dep_rdata_b;
                end else begin
                    n_delta = dep_rdata_b - dep_rdata_a;
                end
                n_lvl   = '0;
                n_state = ST_Q_LIFT;
            end
            ST_Q_LIFT: begin
                jmp_raddr_a = {f_slot(r_v), r_lvl};
                if (lift_bits[0]) begin
                    n_state = ST_Q_LWAIT;
                end else if (r_lvl == LIFT_LAST) begin
                    n_state = ST_Q_CMP;
                end else begin
                    n_lvl = r_lvl + 1'b1;
                end
            end
            ST_Q_LWAIT: begin
                n_v = jmp_rdata_a;
                if (r_lvl == LIFT_LAST) begin
                    n_state = ST_Q_CMP;
                end else begin
                    n_lvl   = r_lvl + 1'b1;
                    n_state = ST_Q_LIFT;
                end
            end
            ST_Q_CMP: begin
                dep_raddr_a = f_slot(r_u);
                if (r_u == r_v) begin
                    n_res   = r_u;
                    n_state = ST_Q_RES;
                end else begin
                    n_lvl   = LVL_LAST;
                    n_state = ST_Q_DR;
                end
            end
            ST_Q_DR: begin
                jmp_raddr_a = {f_slot(r_u), r_lvl};
                jmp_raddr_b = {f_slot(r_v), r_lvl};
                n_state     = ST_Q_DW;
            end
            ST_Q_DW: begin
                if (jmp_rdata_a != jmp_rdata_b) begin
                    n_u = jmp_rdata_a;
                    n_v = jmp_rdata_b;
                end
                if (r_lvl == '0) begin
                    n_state = ST_Q_FR;
                end else begin
                    n_lvl   = r_lvl - 1'b1;
                    n_state = ST_Q_DR;
                end
            end
            ST_Q_FR: begin
                jmp_raddr_a = {f_slot(r_u), LVL_W'(0)};
                n_state     = ST_Q_FW;
            end
            ST_Q_FW: begin
                dep_raddr_a = f_slot(jmp_rdata_a);
                n_res       = jmp_rdata_a;
                n_state     = ST_Q_RES;
            end
            ST_Q_RES: begin
                n_out_valid = 1'b1;
                n_out_anc   = r_res;
                n_out_lvl   = dep_rdata_a;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_root      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_root <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_u       <= n_u;
        r_v       <= n_v;
        r_delta   <= n_delta;
        r_res     <= n_res;
        r_lvl     <= n_lvl;
        r_out_anc <= n_out_anc;
        r_out_lvl <= n_out_lvl;
    end

    lca_tables #(
        .SLOT_W (SLOT_W),
        .LVL_W  (LVL_W)
    ) u_tables (
        .i_clk         (i_clk),
        .i_jmp_we      (jmp_we),
        .i_jmp_waddr   (jmp_waddr),
        .i_jmp_wdata   (jmp_wdata),
        .i_jmp_raddr_a (jmp_raddr_a),
        .i_jmp_raddr_b (jmp_raddr_b),
        .o_jmp_rdata_a (jmp_rdata_a),
        .o_jmp_rdata_b (jmp_rdata_b),
        .i_dep_we      (dep_we),
        .i_dep_waddr   (dep_waddr),
        .i_dep_wdata   (dep_wdata),
        .i_dep_raddr_a (dep_raddr_a),
        .i_dep_raddr_b (dep_raddr_b),
        .o_dep_rdata_a (dep_rdata_a),
        .o_dep_rdata_b (dep_rdata_b)
    );

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.ancestor = r_out_anc;
    assign o_rsp.level    = r_out_lvl;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_RES) |-> !r_out_valid)
        else $error("query result would overwrite a pending response");

    a_lift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_LWAIT) |-> ($past(r_state) == ST_Q_LIFT))
        else $error("lift step taken without a preceding jump read");

    a_root_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT && r_lvl == LVL_LAST) |=>
        (o_rsp.valid && o_rsp.level == '0 && o_rsp.ancestor == $past(r_u)))
        else $error("root attach did not report the root at depth zero");

    a_descend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Q_DR) |-> (r_lvl <= LVL_LAST))
        else $error("descent level beyond the jump table");

endmodule

>>> verif/testbench.sv
// Testbench of the lowest common ancestor engine: random tree building, queries and a checker.
module testbench;

    localparam int NODES  = 1024;
    localparam int LEVELS = 10;
    localparam int LIMIT  = 600000;

    typedef struct packed {
        lca_pkg::t_id ancestor;
        lca_pkg::t_id level;
    } t_answer;

    class lca_scoreboard;
        lca_pkg::t_id jump_tab [NODES][LEVELS];
        lca_pkg::t_id depth_tab [NODES];
        lca_pkg::t_id root_id;
        t_answer      golden_q [$];
        int           errors;
        int           n_attach;
        int           n_query;
        int           deepest;

        function new();
            root_id  = '0;
            errors   = 0;
            n_attach = 0;
            n_query  = 0;
            deepest  = 0;
        endfunction

        function void set_root(lca_pkg::t_id r);
            root_id = r;
        endfunction

        function int pending();
            return golden_q.size();
        endfunction

        function void note_request(lca_pkg::t_op op, lca_pkg::t_id a, lca_pkg::t_id b);
            t_answer      ans;
            lca_pkg::t_id d;
            lca_pkg::t_id u;
            lca_pkg::t_id v;
            lca_pkg::t_id t;
            lca_pkg::t_id x;
            lca_pkg::t_id y;
            lca_pkg::t_id delta;
            if (op == lca_pkg::OP_ATTACH) begin
                n_attach++;
                if (a == root_id) begin
                    d = '0;
                    for (int lv = 0; lv < LEVELS; lv++) jump_tab[a][lv] = a;
                end else begin
                    d = depth_tab[b];
                    if (d != lca_pkg::DEPTH_MAX) d = d + 1'b1;
                    jump_tab[a][0] = b;
                    for (int lv = 1; lv < LEVELS; lv++) begin
                        jump_tab[a][lv] = jump_tab[jump_tab[a][lv-1]][lv-1];
                    end
                end
                depth_tab[a] = d;
                ans.ancestor = a;
                ans.level    = d;
            end else begin
                n_query++;
                u = a;
                v = b;
                if (depth_tab[u] > depth_tab[v]) begin
                    t = u;
                    u = v;
                    v = t;
                end
                delta = depth_tab[v] - depth_tab[u];
                for (int lv = 0; lv < LEVELS; lv++) begin
                    if (delta[lv]) v = jump_tab[v][lv];
                end
                if (u != v) begin
                    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
                        x = jump_tab[u][lv];
                        y = jump_tab[v][lv];
                        if (x != y) begin
                            u = x;
                            v = y;
                        end
                    end
                    u = jump_tab[u][0];
                end
                ans.ancestor = u;
                ans.level    = depth_tab[u];
            end
            golden_q.push_back(ans);
        endfunction

        function void check_response(lca_pkg::t_id anc, lca_pkg::t_id lvl);
            t_answer golden;
            if (golden_q.size() == 0) begin
                $error("response with no request pending: ancestor %0d level %0d", anc, lvl);
                errors++;
                return;
            end
            golden = golden_q.pop_front();
            if (anc != golden.ancestor) begin
                $error("ancestor mismatch: expected %0d, actual %0d", golden.ancestor, anc);
                errors++;
            end
            if (lvl != golden.level) begin
                $error("level mismatch: expected %0d, actual %0d", golden.level, lvl);
                errors++;
            end
            if (int'(lvl) > deepest) deepest = int'(lvl);
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    lca_pkg::t_id i_cfg_wr_data;

    lca_req_if req_ch ();
    lca_rsp_if rsp_ch ();

    tree_lca_binary_lifting u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_ch),
        .o_rsp         (rsp_ch)
    );

    lca_scoreboard sb = new();

    bit           burst;
    bit           req_up;
    int           req_gap;
    int           cycles;
    int           n_roots;
    lca_pkg::t_id cur_root;
    bit           attached_flag [NODES];
    lca_pkg::t_id attached_list [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                sb.note_request(lca_pkg::t_op'(req_ch.operation), req_ch.node_id,
                                req_ch.other_node);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                sb.check_response(rsp_ch.ancestor, rsp_ch.level);
            end
        end
    end

    function automatic int next_gap();
        return burst ? 0 : int'($urandom_range(0, 15));
    endfunction

    function automatic lca_pkg::t_id pick_attached();
        return attached_list[$urandom_range(0, attached_list.size() - 1)];
    endfunction

    task automatic send_request(lca_pkg::t_op op, lca_pkg::t_id a, lca_pkg::t_id b);
        if (req_gap > 0) repeat (req_gap) @(posedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.node_id    <= a;
        req_ch.other_node <= b;
        req_up = 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if ($urandom_range(0, 49) == 0) burst = !burst;
        req_gap = next_gap();
        if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_up = 1'b0;
        end
    endtask

    task automatic send_attach(lca_pkg::t_id node, lca_pkg::t_id parent);
        send_request(lca_pkg::OP_ATTACH, node, parent);
        if (!attached_flag[node]) begin
            attached_flag[node] = 1'b1;
            attached_list.push_back(node);
        end
    endtask

    task automatic release_request();
        if (req_up) begin
            req_ch.valid <= 1'b0;
            req_up = 1'b0;
        end
    endtask

    task automatic set_root(lca_pkg::t_id r);
        release_request();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= r;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_root(r);
        cur_root = r;
        n_roots++;
    endtask

    initial begin : response_side
        int  stall;
        bit  rdy_up;
        rdy_up = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = next_gap();
            if (stall > 0) begin
                if (rdy_up) begin
                    rsp_ch.ready <= 1'b0;
                    rdy_up = 1'b0;
                end
                repeat (stall) @(posedge i_clk);
            end
            if (!rdy_up) begin
                rsp_ch.ready <= 1'b1;
                rdy_up = 1'b1;
            end
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        lca_pkg::t_id ids [$];
        lca_pkg::t_id prev;
        lca_pkg::t_id tmp;
        int           j;
        int           roll;

        n_roots = 0;
        burst   = 1'b0;
        req_up  = 1'b0;
        req_gap = 0;
        i_rst_n           <= 1'b0;
        i_cfg_wr_en       <= 1'b0;
        i_cfg_wr_data     <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.operation  <= lca_pkg::OP_ATTACH;
        req_ch.node_id    <= '0;
        req_ch.other_node <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: small hand-built tree with siblings, re-attach and a cycle.
        set_root(lca_pkg::t_id'(0));
        send_attach(lca_pkg::t_id'(0), lca_pkg::t_id'(1023));
        send_attach(lca_pkg::t_id'(1023), lca_pkg::t_id'(0));
        send_attach(lca_pkg::t_id'(512), lca_pkg::t_id'(1023));
        send_attach(lca_pkg::t_id'(341), lca_pkg::t_id'(0));
        send_attach(lca_pkg::t_id'(682), lca_pkg::t_id'(341));
        send_attach(lca_pkg::t_id'(1), lca_pkg::t_id'(682));
        send_request(lca_pkg::OP_QUERY, lca_pkg::t_id'(0), lca_pkg::t_id'(0));
        send_request(lca_pkg::OP_QUERY, lca_pkg::t_id'(1023), lca_pkg::t_id'(1023));
        send_request(lca_pkg::OP_QUERY, lca_pkg::t_id'(512), lca_pkg::t_id'(1));
        send_request(lca_pkg::OP_QUERY, lca_pkg::t_id'(1), lca_pkg::t_id'(341));
        send_request(lca_pkg::OP_QUERY, lca_pkg::t_id'(512), lca_pkg::t_id'(1023));
        send_request(lca_pkg::OP_QUERY, lca_pkg::t_id'(1023), lca_pkg::t_id'(341));
        send_request(lca_pkg::OP_QUERY, lca_pkg::t_id'(1), lca_pkg::t_id'(512));
        send_attach(lca_pkg::t_id'(1), lca_pkg::t_id'(1023));
        send_request(lca_pkg::OP_QUERY, lca_pkg::t_id'(1), lca_pkg::t_id'(512));
        send_attach(lca_pkg::t_id'(1023), lca_pkg::t_id'(512));
        send_request(lca_pkg::OP_QUERY, lca_pkg::t_id'(512), lca_pkg::t_id'(1));
        send_request(lca_pkg::OP_QUERY, lca_pkg::t_id'(682), lca_pkg::t_id'(1023));
        set_root(lca_pkg::t_id'(1023));
        send_attach(lca_pkg::t_id'(1023), lca_pkg::t_id'(5));
        send_attach(lca_pkg::t_id'(0), lca_pkg::t_id'(1023));
        send_request(lca_pkg::OP_QUERY, lca_pkg::t_id'(0), lca_pkg::t_id'(682));
        send_request(lca_pkg::OP_QUERY, lca_pkg::t_id'(1023), lca_pkg::t_id'(0));

        // Random bushy tree under a random root.
        set_root(lca_pkg::t_id'($urandom_range(0, NODES - 1)));
        send_attach(cur_root, lca_pkg::t_id'($urandom_range(0, NODES - 1)));
        for (int k = 0; k < 60; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                send_attach(cur_root, lca_pkg::t_id'($urandom_range(0, NODES - 1)));
            end else if (roll < 50) begin
                send_attach(lca_pkg::t_id'($urandom_range(0, NODES - 1)), pick_attached());
            end else begin
                send_request(lca_pkg::OP_QUERY, pick_attached(), pick_attached());
            end
        end

        // One long chain through every identifier until the depth saturates.
        set_root(lca_pkg::t_id'($urandom_range(0, NODES - 1)));
        send_attach(cur_root, lca_pkg::t_id'($urandom_range(0, NODES - 1)));
        for (int k = 0; k < NODES; k++) begin
            if (lca_pkg::t_id'(k) != cur_root) ids.push_back(lca_pkg::t_id'(k));
        end
        for (int k = ids.size() - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = ids[k];
            ids[k] = ids[j];
            ids[j] = tmp;
        end
        prev = cur_root;
        foreach (ids[k]) begin
            if ($urandom_range(0, 99) < 8) begin
                send_request(lca_pkg::OP_QUERY, pick_attached(), pick_attached());
            end
            send_attach(ids[k], prev);
            prev = ids[k];
        end
        send_attach(ids[0], prev);
        for (int k = 0; k < 20; k++) begin
            if ($urandom_range(0, 1) == 0) begin
                send_attach(pick_attached(), pick_attached());
            end else begin
                send_request(lca_pkg::OP_QUERY, pick_attached(), pick_attached());
            end
        end

        release_request();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d attaches and %0d queries under %0d root settings.",
                 sb.n_attach, sb.n_query, n_roots);
        $display("Deepest level answered was %0d.", sb.deepest);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
